// ----- hdl/assert_macros.svh -----
// Shared assertion macros for the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define CMAP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CMAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CMAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cmap_pkg.sv -----
package cmap_pkg;

    localparam int MAX_IDS = 1024;
    localparam int ID_BITS = 63;
    localparam int AW      = $clog2(MAX_IDS);
    localparam int CW      = $clog2(MAX_IDS + 1);
    localparam int DENSE_W = 10;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 10;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_FETCH,
        ST_HOLD,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Stored word: first-occurrence mark beside the id.
    typedef struct packed {
        logic               first;
        logic [ID_BITS-1:0] id;
    } t_id_word;

    typedef struct packed {
        logic          id_we;
        logic          rank_we;
        logic [AW-1:0] waddr;
        logic [AW-1:0] raddr;
        t_id_word      id_wdata;
        logic [AW-1:0] rank_wdata;
    } t_store_ctl;

    typedef struct packed {
        logic clr;
        logic step;
        logic less_mode;
    } t_unit_ctl;

endpackage

// ----- hdl/cmap_store.sv -----
module cmap_store (
    input  logic                  i_clk,
    input  cmap_pkg::t_store_ctl  i_ctl,
    output cmap_pkg::t_id_word    o_id_rdata,
    output logic [cmap_pkg::AW-1:0] o_rank_rdata
);
    import cmap_pkg::*;

    t_id_word      r_id_mem   [MAX_IDS];
    logic [AW-1:0] r_rank_mem [MAX_IDS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.id_we) begin
            r_id_mem[i_ctl.waddr] <= i_ctl.id_wdata;
        end
        o_id_rdata <= r_id_mem[i_ctl.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rank_we) begin
            r_rank_mem[i_ctl.waddr] <= i_ctl.rank_wdata;
        end
        o_rank_rdata <= r_rank_mem[i_ctl.raddr];
    end

endmodule

// ----- hdl/cmap_rank_unit.sv -----
module cmap_rank_unit (
    input  logic                         i_clk,
    input  cmap_pkg::t_unit_ctl          i_ctl,
    input  logic [cmap_pkg::ID_BITS-1:0] i_cur,
    input  cmap_pkg::t_id_word           i_word,
    output logic [cmap_pkg::AW-1:0]      o_acc,
    output logic                         o_hit
);
    import cmap_pkg::*;

    logic w_eq;
    logic w_lt;

    assign w_eq = (i_word.id == i_cur);
    assign w_lt = i_word.first && (i_word.id < i_cur);

    // Equality mode latches a duplicate hit; less mode counts smaller distinct ids.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            o_acc <= '0;
            o_hit <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.less_mode) begin
                o_acc <= o_acc + AW'(w_lt);
            end else begin
                o_hit <= o_hit | w_eq;
            end
        end
    end

endmodule

// ----- hdl/id_compression_map.sv -----
// A load without last answers in the cycle after its transfer; a query in range first
// reads the memories in ST_QUERY. A load with last ranks the list first: one compare
// unit scans the id memory one word per cycle, each entry against the earlier
// entries, then against the whole list.
// Throughput: one item at a time; no new transfer until the result is taken.
// Reset (i_rst_n low, synchronous) empties the list and clears the ranked state;
// the memories are not cleared, and only written entries are ever read.
module id_compression_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,  // vertex_id[62:0], position[72:63], zero pad
    input  logic        i_s_tuser,  // action
    input  logic        i_s_tlast,  // last_load
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // dense_index[9:0], mapped[10],
                                    // distinct_count[21:11], overflow[22], zero pad
);
    import cmap_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_total;
    logic               r_ranked;
    logic               r_phase;     // 0: first-occurrence pass, 1: rank pass
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic               r_dv;        // read data of the scan is valid this cycle
    logic [ID_BITS-1:0] r_cur;
    logic               r_ovf_hold;  // overflow of the load that started ranking

    logic [DENSE_W-1:0] r_dense;
    logic               r_mapped;
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;
    logic               r_ovalid;

    t_store_ctl         w_sctl;
    t_unit_ctl          w_uctl;
    t_id_word           w_rd_word;
    logic [AW-1:0]      w_rd_rank;
    logic [AW-1:0]      w_acc;
    logic               w_hit;

    logic               w_acc_in;
    t_action            w_act;
    logic [ID_BITS-1:0] w_id;
    logic [POS_W-1:0]   w_pos;
    logic [CW-1:0]      w_eff;
    logic               w_full;
    logic               w_qok;
    logic [CW-1:0]      w_lim;
    logic               w_scan_go;
    logic               w_fetch_end;
    logic               w_first;

    assign o_s_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign w_acc_in   = i_s_tvalid && o_s_tready;
    assign w_act      = t_action'(i_s_tuser);
    assign w_id       = i_s_tdata[ID_BITS-1:0];
    assign w_pos      = i_s_tdata[ID_BITS +: POS_W];

    // A load after ranking starts a new list.
    assign w_eff       = r_ranked ? '0 : r_cnt;
    assign w_full      = (w_eff >= CW'(MAX_IDS));
    assign w_qok       = r_ranked && (CW'(w_pos) < r_cnt);
    assign w_lim       = r_phase ? r_cnt : r_i;
    assign w_scan_go   = (r_j < w_lim);
    assign w_fetch_end = (r_i >= r_cnt);
    assign w_first     = (r_cur != '0) && !w_hit;

    cmap_store u_store (
        .i_clk        (i_clk),
        .i_ctl        (w_sctl),
        .o_id_rdata   (w_rd_word),
        .o_rank_rdata (w_rd_rank)
    );

    cmap_rank_unit u_unit (
        .i_clk  (i_clk),
        .i_ctl  (w_uctl),
        .i_cur  (r_cur),
        .i_word (w_rd_word),
        .o_acc  (w_acc),
        .o_hit  (w_hit)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    if (w_act == ACT_LOAD) begin
                        n_state = i_s_tlast ? ST_FETCH : ST_IDLE;
                    end else begin
                        n_state = w_qok ? ST_QUERY : ST_IDLE;
                    end
                end
            end
            ST_QUERY: n_state = ST_IDLE;
            ST_FETCH: begin
                if (w_fetch_end) begin
                    n_state = r_phase ? ST_IDLE : ST_FETCH;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: n_state = ST_SCAN;
            ST_SCAN: begin
                if (!w_scan_go && !r_dv) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:  n_state = ST_FETCH;
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory and compare-unit controls.
    always_comb begin
        w_sctl            = '0;
        w_uctl            = '0;
        w_uctl.less_mode  = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                w_sctl.raddr = AW'(w_pos);
                w_sctl.waddr = w_eff[AW-1:0];
                w_sctl.id_wdata.first = 1'b0;
                w_sctl.id_wdata.id    = w_id;
                w_sctl.id_we = w_acc_in && (w_act == ACT_LOAD) && !w_full;
            end
            ST_FETCH: begin
                w_sctl.raddr = r_i[AW-1:0];
            end
            ST_HOLD: begin
                w_uctl.clr = 1'b1;
            end
            ST_SCAN: begin
                w_sctl.raddr = r_j[AW-1:0];
                w_uctl.step  = r_dv;
            end
            ST_FIN: begin
                w_sctl.waddr          = r_i[AW-1:0];
                w_sctl.id_wdata.first = w_first;
                w_sctl.id_wdata.id    = r_cur;
                w_sctl.id_we          = !r_phase;
                w_sctl.rank_wdata     = (r_cur == '0) ? '0 : w_acc;
                w_sctl.rank_we        = r_phase;
            end
            default: begin
                w_sctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_ranked <= 1'b0;
            r_phase  <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Drop the result once the transfer completes.
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        if (w_act == ACT_LOAD) begin
                            r_ranked   <= 1'b0;
                            r_total    <= '0;
                            r_cnt      <= w_full ? w_eff : w_eff + CW'(1);
                            r_ovf_hold <= w_full;
                            r_dense    <= '0;
                            r_mapped   <= 1'b0;
                            r_count    <= '0;
                            r_ovf      <= w_full;
                            if (i_s_tlast) begin
                                r_phase <= 1'b0;
                                r_i     <= '0;
                            end else begin
                                r_ovalid <= 1'b1;
                            end
                        end else if (!w_qok) begin
                            r_dense  <= '0;
                            r_mapped <= 1'b0;
                            r_count  <= COUNT_W'(r_total);
                            r_ovf    <= 1'b1;
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                ST_QUERY: begin
                    r_mapped <= (w_rd_word.id != '0);
                    r_dense  <= (w_rd_word.id != '0) ? DENSE_W'(w_rd_rank) : '0;
                    r_count  <= COUNT_W'(r_total);
                    r_ovf    <= 1'b0;
                    r_ovalid <= 1'b1;
                end
                ST_FETCH: begin
                    if (w_fetch_end) begin
                        if (r_phase) begin
                            r_ranked <= 1'b1;
                            r_dense  <= '0;
                            r_mapped <= 1'b0;
                            r_count  <= COUNT_W'(r_total);
                            r_ovf    <= r_ovf_hold;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_phase <= 1'b1;
                            r_i     <= '0;
                        end
                    end
                end
                ST_HOLD: begin
                    r_cur <= w_rd_word.id;
                    r_j   <= '0;
                    r_dv  <= 1'b0;
                end
                ST_SCAN: begin
                    if (w_scan_go) begin
                        r_j  <= r_j + CW'(1);
                        r_dv <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                end
                ST_FIN: begin
                    if (!r_phase && w_first) begin
                        r_total <= r_total + CW'(1);
                    end
                    r_i <= r_i + CW'(1);
                end
                default: begin
                    r_dv <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_ovf, r_count, r_mapped, r_dense};

`include "assert_macros.svh"

    `CMAP_ASSERT(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CW'(MAX_IDS), "list count past capacity")
    `CMAP_ASSERT_IMP(a_total_le_cnt, i_clk, i_rst_n, r_ranked, r_total <= r_cnt, "distinct total exceeds list length")
    `CMAP_ASSERT_NXT(a_query_answers, i_clk, i_rst_n, r_state == ST_QUERY, r_ovalid, "query read gave no result")
    `CMAP_ASSERT_IMP(a_rank_in_range, i_clk, i_rst_n, r_ovalid && r_mapped, COUNT_W'(r_dense) < r_count, "dense index not below distinct count")

endmodule

// ----- dv/id_compression_map_tb.sv -----
`timescale 1ns / 100ps

module id_compression_map_tb;
    import cmap_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;

    // One answer of the block, as unpacked from o_m_tdata.
    typedef struct {
        logic [DENSE_W-1:0] dense_index;
        logic               mapped;
        logic [COUNT_W-1:0] distinct_count;
        logic               overflow;
    } t_answer;

    // Scoreboard: mirrors the id list and its ranking, and queues the answers.
    class rank_scoreboard;
        logic [ID_BITS-1:0] id_list[MAX_IDS];
        int unsigned        rank_list[MAX_IDS];
        bit                 first_hit[MAX_IDS];
        int unsigned        n_loaded;
        int unsigned        n_distinct;
        bit                 is_ranked;
        t_answer            pending_answers[$];
        int unsigned        n_errors;
        int unsigned        n_checked;

        function new();
            n_loaded   = 0;
            n_distinct = 0;
            is_ranked  = 0;
            n_errors   = 0;
            n_checked  = 0;
        endfunction

        // Count each nonzero id once, at its first position, then rank by value.
        function void rank_ids();
            int unsigned total;
            int unsigned r;
            bit          first;
            total = 0;
            for (int i = 0; i < n_loaded; i++) begin
                first = id_list[i] != 0;
                for (int j = 0; j < i && first; j++)
                    if (id_list[j] == id_list[i]) first = 0;
                first_hit[i] = first;
                if (first) total++;
            end
            for (int i = 0; i < n_loaded; i++) begin
                r = 0;
                if (id_list[i] != 0)
                    for (int j = 0; j < n_loaded; j++)
                        if (first_hit[j] && id_list[j] < id_list[i]) r++;
                rank_list[i] = r;
            end
            n_distinct = total;
            is_ranked  = 1;
        endfunction

        // Note one accepted input transfer and queue the answer it causes.
        function void note_transfer(t_action act, logic [ID_BITS-1:0] vid,
                                    logic [POS_W-1:0] pos, logic last);
            t_answer a;
            a.dense_index = '0;
            a.mapped      = 0;
            a.overflow    = 0;
            if (act == ACT_LOAD) begin
                if (is_ranked) begin
                    n_loaded   = 0;
                    n_distinct = 0;
                    is_ranked  = 0;
                end
                if (n_loaded < MAX_IDS) begin
                    id_list[n_loaded] = vid;
                    n_loaded++;
                end else begin
                    a.overflow = 1;
                end
                if (last) rank_ids();
            end else begin
                if (!is_ranked || pos >= n_loaded) begin
                    a.overflow = 1;
                end else begin
                    a.mapped = id_list[pos] != 0;
                    if (a.mapped) a.dense_index = rank_list[pos][DENSE_W-1:0];
                end
            end
            a.distinct_count = n_distinct[COUNT_W-1:0];
            pending_answers.push_back(a);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            n_errors++;
        endtask

        // Compare one accepted output transfer with the oldest queued answer.
        task check_answer(logic [23:0] data);
            t_answer want;
            if (pending_answers.size() == 0) begin
                report_mismatch("pending answers", 0, 1);
                return;
            end
            want = pending_answers.pop_front();
            n_checked++;
            if (data[9:0] !== want.dense_index)
                report_mismatch("dense_index", data[9:0], want.dense_index);
            if (data[10] !== want.mapped)
                report_mismatch("mapped", data[10], want.mapped);
            if (data[21:11] !== want.distinct_count)
                report_mismatch("distinct_count", data[21:11], want.distinct_count);
            if (data[22] !== want.overflow)
                report_mismatch("overflow", data[22], want.overflow);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;  // vertex_id[62:0], position[72:63], zero pad
    logic        i_s_tuser;  // action
    logic        i_s_tlast;  // last_load
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;  // dense_index[9:0], mapped[10], distinct_count[21:11], overflow[22]

    rank_scoreboard sb;
    int unsigned    src_idle_pct;
    int unsigned    snk_idle_pct;
    bit             hold_request;
    int unsigned    hold_left;
    int unsigned    cycle_count;
    int unsigned    n_sent;
    int unsigned    n_lists;

    id_compression_map u_top (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Output side: check every transfer, then decide readiness for the next edge.
    // A long hold-off lets the block fill up and back-pressure its input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_answer(o_m_tdata);
        if (hold_request) begin
            hold_request = 0;
            hold_left    = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= $urandom_range(99) >= snk_idle_pct;
        end
    end

    // Offer one item and hold it until the block takes the transfer.
    task automatic send_item(t_action act, logic [ID_BITS-1:0] vid,
                             logic [POS_W-1:0] pos, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= act;
        i_s_tlast  <= last;
        i_s_tdata  <= {7'b0, pos, vid};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_transfer(act, vid, pos, last);
        n_sent++;
    endtask

    function automatic logic [ID_BITS-1:0] pick_id();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        if (sel < 60) return ID_BITS'($urandom_range(12, 1));  // duplicates likely
        if (sel < 65) return {ID_BITS{1'b1}};
        return ID_BITS'({$urandom, $urandom});
    endfunction

    // A loaded list of random length, then queries over it, with some noise.
    task automatic run_list();
        int unsigned len;
        int unsigned n_queries;
        len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
            // a stray query after a load of the list sees it unranked; one before the first load sees the last list
            if ($urandom_range(29) == 0)
                send_item(ACT_QUERY, ID_BITS'({$urandom, $urandom}), POS_W'($urandom), 0);
            send_item(ACT_LOAD, pick_id(), POS_W'($urandom), i == len - 1);
        end
        n_queries = $urandom_range(len + 4, 1);
        for (int i = 0; i < n_queries; i++)
            send_item(ACT_QUERY, ID_BITS'({$urandom, $urandom}),
                      ($urandom_range(9) == 0) ? POS_W'($urandom)
                                               : POS_W'($urandom_range(len + 1)), 0);
        n_lists++;
    endtask

    initial begin
        sb           = new();
        cycle_count  = 0;
        n_sent       = 0;
        n_lists      = 0;
        hold_request = 0;
        hold_left    = 0;
        src_idle_pct = 27;
        snk_idle_pct = 64;
        i_rst_n      = 0;
        i_s_tvalid   = 0;
        i_s_tdata    = '0;
        i_s_tuser    = ACT_LOAD;
        i_s_tlast    = 0;
        i_m_tready   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: query before any ranking, extreme ids, zero, duplicates.
        send_item(ACT_QUERY, '0, '0, 0);
        send_item(ACT_QUERY, {ID_BITS{1'b1}}, {POS_W{1'b1}}, 1);
        send_item(ACT_LOAD, {ID_BITS{1'b1}}, {POS_W{1'b1}}, 0);
        send_item(ACT_LOAD, '0, '0, 0);
        send_item(ACT_LOAD, ID_BITS'(1), '0, 0);
        send_item(ACT_LOAD, {ID_BITS{1'b1}}, '0, 0);
        send_item(ACT_LOAD, ID_BITS'(5), '0, 1);
        for (int p = 0; p < 6; p++) send_item(ACT_QUERY, '0, POS_W'(p), 0);
        send_item(ACT_QUERY, '0, {POS_W{1'b1}}, 0);
        // Load after ranking starts a new single-entry list of id zero.
        send_item(ACT_LOAD, '0, '0, 1);
        send_item(ACT_QUERY, '0, '0, 0);
        send_item(ACT_QUERY, '0, POS_W'(1), 0);

        // Phase one, with a long receiver hold-off while items keep coming.
        hold_request = 1;
        while (n_sent < 450) run_list();
        src_idle_pct = 64;
        snk_idle_pct = 27;
        while (n_sent < 850) run_list();
        src_idle_pct = 0;
        snk_idle_pct = 0;

        // Full list: the load past capacity is dropped, and its last still ranks.
        for (int i = 0; i <= MAX_IDS; i++)
            send_item(ACT_LOAD, ID_BITS'($urandom_range(300)), '0, i == MAX_IDS);
        send_item(ACT_QUERY, '0, '0, 0);
        send_item(ACT_QUERY, '0, {POS_W{1'b1}}, 0);
        for (int i = 0; i < 20; i++) send_item(ACT_QUERY, '0, POS_W'($urandom), 0);

        while (n_sent < 2000) run_list();
        i_s_tvalid <= 0;

        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d items in %0d lists, checked %0d answers", n_sent, n_lists,
                 sb.n_checked);
        $display("covered idle mixes, a long output stall and a full list");
        if (sb.n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cmap_pkg.sv
hdl/cmap_store.sv
hdl/cmap_rank_unit.sv
hdl/id_compression_map.sv
dv/id_compression_map_tb.sv
